// File: src/depth_pixel_backprojection_macros.svh
// Assertion macros shared by the depth pixel back-projection RTL.
`ifndef DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define DPB_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define DPB_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/dpb_pkg.sv
// Package with widths, register codes and the point type of the back-projection block.
package dpb_pkg;

  // Pixel coordinate bits that take part in the projection.
  localparam int COORD_BITS = 12;

  // Field widths.
  localparam int CoordW  = 12;
  localparam int DepthW  = 16;
  localparam int ColorW  = 8;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 8;
  localparam int PointW  = 32;

  // Arithmetic widths: magnitude of 16*u - c, product with depth, scaled dividend.
  localparam int MagW    = 16;
  localparam int ProdW   = MagW + DepthW;
  localparam int NumBits = ProdW + 4 + 1;

  // Only the low COORD_BITS bits of a coordinate are used.
  localparam logic [CoordW-1:0] CoordMask = CoordW'((64'd1 << COORD_BITS) - 64'd1);

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_FOCAL_X  = 8'd0,
    REG_FOCAL_Y  = 8'd1,
    REG_CENTER_X = 8'd2,
    REG_CENTER_Y = 8'd3
  } cfg_reg_e;

  // Register reset values, all in 1/16 pixel.
  localparam logic [CfgW-1:0] FocalXRst  = 16'd8400;
  localparam logic [CfgW-1:0] FocalYRst  = 16'd8400;
  localparam logic [CfgW-1:0] CenterXRst = 16'd5112;
  localparam logic [CfgW-1:0] CenterYRst = 16'd3832;

  // One output point.
  typedef struct packed {
    logic                     point_valid;
    logic signed [PointW-1:0] point_x;
    logic signed [PointW-1:0] point_y;
    logic [DepthW-1:0]        point_z;
    logic [ColorW-1:0]        out_blue;
    logic [ColorW-1:0]        out_green;
    logic [ColorW-1:0]        out_red;
  } point_t;

endpackage

// File: src/dpb_intf.sv
// Handshake interfaces for the pixel, point and configuration channels.
interface dpb_pixel_if;
  import dpb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CoordW-1:0] column;
  logic [CoordW-1:0] row;
  logic [DepthW-1:0] depth_mm;
  logic [ColorW-1:0] blue;
  logic [ColorW-1:0] green;
  logic [ColorW-1:0] red;

  modport source (output valid, column, row, depth_mm, blue, green, red, input ready);
  modport sink   (input valid, column, row, depth_mm, blue, green, red, output ready);
endinterface

interface dpb_point_if;
  import dpb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     point_valid;
  logic signed [PointW-1:0] point_x;
  logic signed [PointW-1:0] point_y;
  logic [DepthW-1:0]        point_z;
  logic [ColorW-1:0]        out_blue;
  logic [ColorW-1:0]        out_green;
  logic [ColorW-1:0]        out_red;

  modport source (output valid, point_valid, point_x, point_y, point_z, out_blue, out_green,
                  out_red, input ready);
  modport sink   (input valid, point_valid, point_x, point_y, point_z, out_blue, out_green,
                  out_red, output ready);
endinterface

interface dpb_cfg_if;
  import dpb_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/depth_pixel_backprojection.sv
// Pinhole back-projection of depth pixels into colored 3D points.
//
// Channels: pixel_i takes one item per pixel (column, row, depth in mm, BGR color);
// point_o returns one item per pixel (valid flag, X and Y in signed 1/16 mm, Z in mm,
// color). cfg_i writes focal_x (0), focal_y (1), center_x (2) and center_y (3), all in
// 1/16 pixel; other indexes are ignored. cfg_i is always ready; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Throughput is one item per cycle while the receiver does not stall. On its way from
// pixel_i to point_o, one stage forms 16*u - c, one multiplies by the depth, one adds the
// rounding term, 37 stages run a one-bit-per-stage restoring division, one saturates, and
// the output register holds it. The divider pipeline sets the latency.
// Reset loads the register defaults and empties the pipeline. When the receiver stalls,
// the next item is parked in a skid register and the whole pipeline then holds; pixel_i
// ready is the registered "skid empty" flag, so no item is lost or repeated.
// A pixel with zero depth gives point_valid low and zero coordinates.
`include "depth_pixel_backprojection_macros.svh"

module depth_pixel_backprojection (
  input logic    clk_i,
  input logic    rst_ni,
  dpb_cfg_if.sink    cfg_i,
  dpb_pixel_if.sink  pixel_i,
  dpb_point_if.source point_o
);
  import dpb_pkg::*;

  // One divider lane: sign, divisor, partial remainder, dividend/quotient shifter.
  typedef struct packed {
    logic               neg;
    logic [CfgW-1:0]    den;
    logic [CfgW-1:0]    rem;
    logic [NumBits-1:0] dq;
  } div_lane_t;

  typedef struct packed {
    div_lane_t         lane_x;
    div_lane_t         lane_y;
    logic [DepthW-1:0] z;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
  } div_stage_t;

  // First stage: offset from the principal point as sign and magnitude.
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
    logic [CfgW-1:0] den;
  } off_lane_t;

  typedef struct packed {
    off_lane_t         lane_x;
    off_lane_t         lane_y;
    logic [DepthW-1:0] z;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
  } off_stage_t;

  // Second stage: product of magnitude and depth.
  typedef struct packed {
    logic             neg;
    logic [ProdW-1:0] prod;
    logic [CfgW-1:0]  den;
  } prod_lane_t;

  typedef struct packed {
    prod_lane_t        lane_x;
    prod_lane_t        lane_y;
    logic [DepthW-1:0] z;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
  } prod_stage_t;

  // Sign, magnitude and safe divisor for one axis.
  function automatic off_lane_t make_offset(logic [CoordW-1:0] p, logic [CfgW-1:0] c,
                                            logic [CfgW-1:0] f);
    logic [CfgW:0] diff;
    off_lane_t     res;
    diff     = {1'b0, 4'(0), p & CoordMask} * 17'd0 + {1'b0, p & CoordMask, 4'b0000}
               - {1'b0, c};
    res.neg  = diff[CfgW];
    res.mag  = res.neg ? MagW'(-diff) : diff[MagW-1:0];
    res.den  = (f == '0) ? CfgW'(1) : f;
    return res;
  endfunction

  // One restoring division step: one quotient bit.
  function automatic div_lane_t div_step(div_lane_t in);
    logic [CfgW:0] r;
    logic          ge;
    div_lane_t     res;
    r       = {in.rem, in.dq[NumBits-1]};
    ge      = r >= {1'b0, in.den};
    res     = in;
    res.rem = ge ? CfgW'(r - {1'b0, in.den}) : r[CfgW-1:0];
    res.dq  = {in.dq[NumBits-2:0], ge};
    return res;
  endfunction

  // Signed result clamped to 32 bits.
  function automatic logic signed [PointW-1:0] clamp(logic neg, logic [NumBits-1:0] q);
    logic signed [PointW-1:0] res;
    if (neg) begin
      if ((|q[NumBits-1:PointW]) || (q[PointW-1] && (|q[PointW-2:0]))) begin
        res = {1'b1, {(PointW-1){1'b0}}};
      end else begin
        res = PointW'(-q);
      end
    end else begin
      if (|q[NumBits-1:PointW-1]) begin
        res = {1'b0, {(PointW-1){1'b1}}};
      end else begin
        res = q[PointW-1:0];
      end
    end
    return res;
  endfunction

  // Configuration registers.
  logic [CfgW-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FocalXRst;
      focal_y_q  <= FocalYRst;
      center_x_q <= CenterXRst;
      center_y_q <= CenterYRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_FOCAL_X:  focal_x_q  <= cfg_i.data;
        REG_FOCAL_Y:  focal_y_q  <= cfg_i.data;
        REG_CENTER_X: center_x_q <= cfg_i.data;
        REG_CENTER_Y: center_y_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Pipeline control: everything advances unless the skid register is occupied.
  logic pipe_en;
  logic push;
  logic skid_vld_q;
  logic out_vld_q;
  logic sat_vld_q;

  assign pipe_en       = !skid_vld_q;
  assign pixel_i.ready = pipe_en;
  assign push          = pipe_en && sat_vld_q;

  // Offset stage.
  off_stage_t off_q, off_d;
  logic       off_vld_q;

  always_comb begin
    off_d.lane_x = make_offset(pixel_i.column, center_x_q, focal_x_q);
    off_d.lane_y = make_offset(pixel_i.row, center_y_q, focal_y_q);
    off_d.z      = pixel_i.depth_mm;
    off_d.blue   = pixel_i.blue;
    off_d.green  = pixel_i.green;
    off_d.red    = pixel_i.red;
  end

  // Product stage.
  prod_stage_t prod_q, prod_d;
  logic        prod_vld_q;

  always_comb begin
    prod_d.lane_x.neg  = off_q.lane_x.neg;
    prod_d.lane_x.den  = off_q.lane_x.den;
    prod_d.lane_x.prod = ProdW'(off_q.lane_x.mag) * ProdW'(off_q.z);
    prod_d.lane_y.neg  = off_q.lane_y.neg;
    prod_d.lane_y.den  = off_q.lane_y.den;
    prod_d.lane_y.prod = ProdW'(off_q.lane_y.mag) * ProdW'(off_q.z);
    prod_d.z           = off_q.z;
    prod_d.blue        = off_q.blue;
    prod_d.green       = off_q.green;
    prod_d.red         = off_q.red;
  end

  // Divider stages: entry 0 holds the scaled dividend plus half the divisor.
  div_stage_t div_q [NumBits+1];
  logic       div_vld_q [NumBits+1];
  div_stage_t div0_d;

  always_comb begin
    div0_d.lane_x.neg = prod_q.lane_x.neg;
    div0_d.lane_x.den = prod_q.lane_x.den;
    div0_d.lane_x.rem = '0;
    div0_d.lane_x.dq  = NumBits'({prod_q.lane_x.prod, 4'b0000})
                        + NumBits'(prod_q.lane_x.den >> 1);
    div0_d.lane_y.neg = prod_q.lane_y.neg;
    div0_d.lane_y.den = prod_q.lane_y.den;
    div0_d.lane_y.rem = '0;
    div0_d.lane_y.dq  = NumBits'({prod_q.lane_y.prod, 4'b0000})
                        + NumBits'(prod_q.lane_y.den >> 1);
    div0_d.z          = prod_q.z;
    div0_d.blue       = prod_q.blue;
    div0_d.green      = prod_q.green;
    div0_d.red        = prod_q.red;
  end

  // Front stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_vld_q    <= 1'b0;
      prod_vld_q   <= 1'b0;
      div_vld_q[0] <= 1'b0;
    end else if (pipe_en) begin
      off_vld_q    <= pixel_i.valid;
      prod_vld_q   <= off_vld_q;
      div_vld_q[0] <= prod_vld_q;
    end
  end

  // Front stage payload.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      off_q    <= off_d;
      prod_q   <= prod_d;
      div_q[0] <= div0_d;
    end
  end

  // One quotient bit per stage for both axes.
  for (genvar k = 0; k < NumBits; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[k+1] <= 1'b0;
      end else if (pipe_en) begin
        div_vld_q[k+1] <= div_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        div_q[k+1].lane_x <= div_step(div_q[k].lane_x);
        div_q[k+1].lane_y <= div_step(div_q[k].lane_y);
        div_q[k+1].z      <= div_q[k].z;
        div_q[k+1].blue   <= div_q[k].blue;
        div_q[k+1].green  <= div_q[k].green;
        div_q[k+1].red    <= div_q[k].red;
      end
    end
  end

  // Saturation stage.
  point_t sat_q, sat_d;

  always_comb begin
    sat_d.point_valid = div_q[NumBits].z != '0;
    sat_d.point_x     = clamp(div_q[NumBits].lane_x.neg, div_q[NumBits].lane_x.dq);
    sat_d.point_y     = clamp(div_q[NumBits].lane_y.neg, div_q[NumBits].lane_y.dq);
    sat_d.point_z     = div_q[NumBits].z;
    sat_d.out_blue    = div_q[NumBits].blue;
    sat_d.out_green   = div_q[NumBits].green;
    sat_d.out_red     = div_q[NumBits].red;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_vld_q <= 1'b0;
    end else if (pipe_en) begin
      sat_vld_q <= div_vld_q[NumBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sat_q <= sat_d;
    end
  end

  // Output register with a skid register behind it.
  point_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || point_o.ready) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= push;
      end
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || point_o.ready) begin
      out_q <= skid_vld_q ? skid_q : sat_q;
    end else if (push) begin
      skid_q <= sat_q;
    end
  end

  // Output channel.
  assign point_o.valid       = out_vld_q;
  assign point_o.point_valid = out_q.point_valid;
  assign point_o.point_x     = out_q.point_x;
  assign point_o.point_y     = out_q.point_y;
  assign point_o.point_z     = out_q.point_z;
  assign point_o.out_blue    = out_q.out_blue;
  assign point_o.out_green   = out_q.out_green;
  assign point_o.out_red     = out_q.out_red;

  // Assertions.
  `DPB_ASSERT_NOW(a_skid_behind_out, clk_i, rst_ni, skid_vld_q, out_vld_q, "skid holds an item while the output register is empty")
  `DPB_ASSERT_NEXT(a_push_to_skid, clk_i, rst_ni, out_vld_q && !point_o.ready && push, skid_vld_q, "item pushed into a held output was not parked")
  `DPB_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !pipe_en, $stable(sat_vld_q) && $stable(div_vld_q[NumBits]), "pipeline moved during a stall")
  `DPB_ASSERT_NOW(a_no_point_zero, clk_i, rst_ni, out_vld_q && !out_q.point_valid, out_q.point_x == 0 && out_q.point_y == 0 && out_q.point_z == 0, "invalid point carries nonzero coordinates")

endmodule

// File: sim/depth_pixel_backprojection_tb.sv
// Self-checking testbench for the depth pixel back-projection block.
module depth_pixel_backprojection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpb_pkg::*;

  localparam int ItemsPerPhase = 105;
  localparam int RandomPhases  = 12;
  localparam int SettleCycles  = 60;
  localparam int LimitNs       = 2_000_000;

  // Register indexes above the last defined one are ignored by the block.
  localparam logic [CfgIdxW-1:0] FirstUnusedReg = 8'd4;

  typedef struct {
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
    logic [DepthW-1:0] depth_mm;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
  } pixel_t;

  logic clk;
  logic rst_n;

  dpb_cfg_if   cfg_if ();
  dpb_pixel_if pix_if ();
  dpb_point_if pt_if ();

  depth_pixel_backprojection u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_if),
    .pixel_i (pix_if),
    .point_o (pt_if)
  );

  // Camera settings as the block should hold them.
  logic [CfgW-1:0] focal_x_q  = FocalXRst;
  logic [CfgW-1:0] focal_y_q  = FocalYRst;
  logic [CfgW-1:0] center_x_q = CenterXRst;
  logic [CfgW-1:0] center_y_q = CenterYRst;

  point_t pending_points[$];
  int     mismatch_count = 0;
  int     burst_left     = 0;
  bit     sender_eager   = 1'b0;
  int     stall_cycle    = 0;
  int     stall_mode     = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Back-projects one axis: 16*(16*p - c)*z/f, rounded half away from zero, clamped.
  function automatic logic signed [PointW-1:0] backproject_axis(
    input logic [CoordW-1:0] coord,
    input logic [CfgW-1:0]   center,
    input logic [DepthW-1:0] depth,
    input logic [CfgW-1:0]   focal
  );
    longint diff;
    longint mag;
    longint den;
    longint quot;
    diff = 16 * longint'(coord & CoordMask) - longint'(center);
    mag  = (diff < 0) ? -diff : diff;
    den  = (focal == '0) ? 1 : longint'(focal);
    quot = (mag * longint'(depth) * 16 + den / 2) / den;
    if (diff < 0) begin
      if (quot > 64'sd2147483648) quot = 64'sd2147483648;
      return PointW'(-quot);
    end
    if (quot > 64'sd2147483647) quot = 64'sd2147483647;
    return PointW'(quot);
  endfunction

  // Expected point for one pixel under the current camera settings.
  function automatic point_t predict_point(input pixel_t px);
    point_t pt;
    pt.point_valid = (px.depth_mm != '0);
    pt.point_x     = pt.point_valid ?
                     backproject_axis(px.column, center_x_q, px.depth_mm, focal_x_q) : '0;
    pt.point_y     = pt.point_valid ?
                     backproject_axis(px.row, center_y_q, px.depth_mm, focal_y_q) : '0;
    pt.point_z     = px.depth_mm;
    pt.out_blue    = px.blue;
    pt.out_green   = px.green;
    pt.out_red     = px.red;
    return pt;
  endfunction

  function automatic pixel_t make_pixel(
    input int col, input int row, input int depth, input int b, input int g, input int r
  );
    pixel_t px;
    px.column   = CoordW'(col);
    px.row      = CoordW'(row);
    px.depth_mm = DepthW'(depth);
    px.blue     = ColorW'(b);
    px.green    = ColorW'(g);
    px.red      = ColorW'(r);
    return px;
  endfunction

  // Depth leans toward zero, the top of the range and small values.
  function automatic pixel_t random_pixel();
    int depth;
    case ($urandom_range(0, 7))
      0:       depth = 0;
      1:       depth = 65535;
      2:       depth = $urandom_range(1, 15);
      default: depth = $urandom_range(0, 65535);
    endcase
    return make_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), depth,
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  function automatic logic [CfgW-1:0] random_focal();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'd16;
      2:       return 16'hFFFF;
      default: return CfgW'($urandom_range(16, 65535));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] random_center();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 16'hFFFF;
      default: return CfgW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Sends one pixel item; valid stays high afterwards so bursts run back to back.
  task automatic send_pixel(input pixel_t px);
    int gap;
    if (burst_left == 0) begin
      gap = sender_eager ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    pix_if.valid    <= 1'b1;
    pix_if.column   <= px.column;
    pix_if.row      <= px.row;
    pix_if.depth_mm <= px.depth_mm;
    pix_if.blue     <= px.blue;
    pix_if.green    <= px.green;
    pix_if.red      <= px.red;
    do @(posedge clk); while (!pix_if.ready);
    pending_points.insert(pending_points.size(), predict_point(px));
    burst_left--;
  endtask

  // Holds the pixel channel until every expected point has come back.
  task automatic wait_for_drain();
    pix_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_FOCAL_X:  focal_x_q  = value;
      REG_FOCAL_Y:  focal_y_q  = value;
      REG_CENTER_X: center_x_q = value;
      REG_CENTER_Y: center_y_q = value;
      default:      ;
    endcase
  endtask

  // Loads all four registers while the block is idle, optionally with a stray write.
  task automatic configure(
    input logic [CfgW-1:0] fx, input logic [CfgW-1:0] fy,
    input logic [CfgW-1:0] cx, input logic [CfgW-1:0] cy, input bit stray_write
  );
    wait_for_drain();
    write_register(REG_FOCAL_X, fx);
    write_register(REG_FOCAL_Y, fy);
    if (stray_write) begin
      write_register(CfgIdxW'($urandom_range(FirstUnusedReg, 255)), CfgW'($urandom));
    end
    write_register(REG_CENTER_X, cx);
    write_register(REG_CENTER_Y, cy);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Checks each accepted point and drives the receiver's stall pattern.
  always @(posedge clk) begin
    point_t exp_pt;
    if (rst_n && pt_if.valid && pt_if.ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: point item with no expectation, actual x %0d y %0d z %0d",
                 $time, pt_if.point_x, pt_if.point_y, pt_if.point_z);
        mismatch_count++;
      end else begin
        exp_pt = pending_points.pop_front();
        check_field("point_valid", exp_pt.point_valid, pt_if.point_valid);
        check_field("point_x", exp_pt.point_x, pt_if.point_x);
        check_field("point_y", exp_pt.point_y, pt_if.point_y);
        check_field("point_z", exp_pt.point_z, pt_if.point_z);
        check_field("out_blue", exp_pt.out_blue, pt_if.out_blue);
        check_field("out_green", exp_pt.out_green, pt_if.out_green);
        check_field("out_red", exp_pt.out_red, pt_if.out_red);
      end
    end
    // The stall pattern switches between free flow, random, periodic and long stalls.
    stall_cycle++;
    if (stall_cycle % 150 == 0) stall_mode = $urandom_range(0, 3);
    if (!rst_n) begin
      pt_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       pt_if.ready <= 1'b1;
        1:       pt_if.ready <= ($urandom_range(0, 99) < 60);
        2:       pt_if.ready <= (stall_cycle % 5) != 0;
        default: pt_if.ready <= (stall_cycle % 23) > 15;
      endcase
    end
  end

  // Pixels under the reset camera: corners, image center, extreme depths and colors.
  task automatic test_reset_config();
    sender_eager = 1'b1;
    send_pixel(make_pixel(320, 240, 1000, 12, 34, 56));
    send_pixel(make_pixel(0, 0, 65535, 0, 0, 0));
    send_pixel(make_pixel(4095, 4095, 65535, 255, 255, 255));
    send_pixel(make_pixel(100, 50, 0, 'hAA, 'h55, 'h0F));
    send_pixel(make_pixel('hAAA, 'h555, 1, 'h55, 'hAA, 'hF0));
    send_pixel(make_pixel('h555, 'hAAA, 'hAAAA, 'h0F, 'hF0, 'hAA));
    send_pixel(make_pixel(4095, 0, 'h5555, 1, 128, 254));
  endtask

  // Tiny focal lengths drive both coordinates past the 32-bit range in each direction.
  task automatic test_saturation();
    configure(16'd16, 16'd16, 16'd0, 16'd0, 1'b0);
    send_pixel(make_pixel(4095, 4095, 65535, 1, 2, 3));
    send_pixel(make_pixel(0, 0, 65535, 4, 5, 6));
    configure(16'd16, 16'd16, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(make_pixel(0, 0, 65535, 7, 8, 9));
    send_pixel(make_pixel(4095, 4095, 65535, 10, 11, 12));
    send_pixel(make_pixel(0, 4095, 0, 13, 14, 15));
  endtask

  // A zero focal length divides by one; writes to unknown indexes change nothing.
  task automatic test_focal_zero_and_bad_index();
    configure(16'd0, 16'd0, CenterXRst, CenterYRst, 1'b1);
    send_pixel(make_pixel(319, 240, 1, 20, 21, 22));
    send_pixel(make_pixel(400, 100, 300, 23, 24, 25));
    configure(16'hFFFF, 16'hFFFF, 16'd32768, 16'd32768, 1'b1);
    send_pixel(make_pixel(4095, 0, 65535, 26, 27, 28));
  endtask

  // Half-way quotients round away from zero on both sides; an exact center gives zero.
  task automatic test_rounding();
    configure(16'd32, 16'd32, 16'd1, 16'd15, 1'b0);
    send_pixel(make_pixel(0, 1, 1, 30, 31, 32));
    send_pixel(make_pixel(1, 0, 1, 33, 34, 35));
    send_pixel(make_pixel(0, 1, 3, 36, 37, 38));
    configure(16'd48, 16'd48, 16'd16, 16'd16, 1'b0);
    send_pixel(make_pixel(1, 1, 40000, 39, 40, 41));
    send_pixel(make_pixel(2, 0, 3, 42, 43, 44));
  endtask

  // Random pixels under a fresh camera setting per phase, extremes in the first two.
  task automatic test_random_phases();
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0:       configure(16'd16, 16'd16, 16'd0, 16'd0, 1'b1);
        1:       configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        2:       configure(FocalXRst, FocalYRst, CenterXRst, CenterYRst, 1'b0);
        default: configure(random_focal(), random_focal(), random_center(), random_center(),
                           $urandom_range(0, 1));
      endcase
      sender_eager = (phase % 3 == 0);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        send_pixel(random_pixel());
        // Once per phase the sender holds off until the block has emptied.
        if (i == ItemsPerPhase / 2) wait_for_drain();
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    pix_if.valid    = 1'b0;
    pix_if.column   = '0;
    pix_if.row      = '0;
    pix_if.depth_mm = '0;
    pix_if.blue     = '0;
    pix_if.green    = '0;
    pix_if.red      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_saturation();
    test_focal_zero_and_bad_index();
    test_rounding();
    test_random_phases();

    wait_for_drain();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LimitNs * 1ns);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
